// ----- src/dbh_pkg.sv -----
// Package with the shared types and constants of the byte hash block.
`timescale 1ns / 1ps

package dbh_pkg;

  localparam logic [31:0] HASH_INIT   = 32'hdeadbeef;
  localparam int          BLOCK_BYTES = 12;
  localparam int          FILL_W      = 4;
  localparam logic [7:0]  CHAR_LOW_A  = 8'h61;
  localparam logic [7:0]  CHAR_LOW_Z  = 8'h7a;
  localparam logic [7:0]  CHAR_UP_A   = 8'h41;
  localparam logic [7:0]  CASE_OFFSET = CHAR_LOW_A - CHAR_UP_A;

  localparam logic [1:0]  REG_SEED_ONE  = 2'd0;
  localparam logic [1:0]  REG_SEED_TWO  = 2'd1;
  localparam logic [1:0]  REG_FOLD_CASE = 2'd2;

  localparam int          QUEUE_DEPTH = 4;
  localparam int          QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int          QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0]  MIX_LAST_ROW = 3'd5;
  localparam logic [2:0]  FIN_LAST_ROW = 3'd6;

  // Work handed from the front to the back. On an init the block field holds
  // the initial words: a and b in the lowest word, c in the next.
  typedef struct packed {
    logic        do_init;
    logic        do_mix;
    logic        do_final;
    logic        final_add;
    logic [95:0] blk;
    logic [95:0] fin_blk;
  } dbh_cmd_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } dbh_words_t;

  typedef enum logic [2:0] {
    ST_FETCH,
    ST_MIX_ADD,
    ST_MIX,
    ST_FIN_ADD,
    ST_FIN,
    ST_EMIT
  } dbh_state_t;

endpackage

// ----- src/dbh_front.sv -----
// Front end: configuration registers, byte intake, case folding and block assembly.
`timescale 1ns / 1ps

module dbh_front import dbh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        first_item,
  input  logic        last_item,
  input  logic [31:0] message_length,
  output logic        cmd_valid,
  output dbh_cmd_t    cmd,
  input  logic        cmd_full
);

  logic [31:0]       seed_one;
  logic [31:0]       seed_two;
  logic              fold_case;
  logic [31:0]       bytes_remaining;
  logic [FILL_W-1:0] block_fill;
  logic [95:0]       block_buffer;

  logic              accept;
  logic [31:0]       rem_eff;
  logic [FILL_W-1:0] fill_eff;
  logic [95:0]       buf_eff;
  logic [31:0]       init_word;
  logic [31:0]       init_c;
  logic [7:0]        byte_val;
  logic              take;
  logic              blk_full;
  logic [FILL_W-1:0] base_fill;
  logic [95:0]       buf_next;
  logic [FILL_W-1:0] fill_next;
  logic [31:0]       rem_next;

  assign in_ready = !cmd_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    rem_eff   = first_item ? message_length : bytes_remaining;
    fill_eff  = first_item ? '0 : block_fill;
    buf_eff   = first_item ? '0 : block_buffer;
    init_word = HASH_INIT + message_length + seed_one;
    init_c    = init_word + seed_two;
    byte_val  = (fold_case && data_byte >= CHAR_LOW_A && data_byte <= CHAR_LOW_Z) ?
                data_byte - CASE_OFFSET : data_byte;
    take      = byte_present && (rem_eff != '0);
    blk_full  = fill_eff == FILL_W'(BLOCK_BYTES);
    base_fill = (take && blk_full) ? '0 : fill_eff;
    buf_next  = (take && blk_full) ? '0 : buf_eff;
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      if (take && base_fill == FILL_W'(i)) begin
        buf_next[i*8 +: 8] = byte_val;
      end
    end
    fill_next = take ? base_fill + 1'b1 : base_fill;
    if (last_item) begin
      rem_next = '0;
    end else if (take) begin
      rem_next = rem_eff - 1'b1;
    end else begin
      rem_next = rem_eff;
    end
  end

  always_comb begin
    cmd.do_init   = first_item;
    cmd.do_mix    = take && blk_full;
    cmd.do_final  = last_item;
    cmd.final_add = fill_next != '0;
    cmd.blk       = first_item ? {32'd0, init_c, init_word} : buf_eff;
    cmd.fin_blk   = buf_next;
    cmd_valid     = accept && (first_item || (take && blk_full) || last_item);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_one        <= '0;
      seed_two        <= '0;
      fold_case       <= 1'b0;
      bytes_remaining <= '0;
      block_fill      <= '0;
      block_buffer    <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_SEED_ONE:  seed_one  <= cfg_data;
          REG_SEED_TWO:  seed_two  <= cfg_data;
          REG_FOLD_CASE: fold_case <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept) begin
        bytes_remaining <= rem_next;
        block_fill      <= fill_next;
        block_buffer    <= buf_next;
      end
    end
  end

endmodule

// ----- src/dbh_queue.sv -----
// Short command queue between the front end and the hash engine.
`timescale 1ns / 1ps

module dbh_queue import dbh_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  dbh_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output dbh_cmd_t head
);

  dbh_cmd_t              slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_CW-1:0]   count;
  logic                  do_push;
  logic                  do_pop;

  assign full      = count == QUEUE_CW'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head      = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

// ----- src/dbh_back.sv -----
// Hash engine: block addition, mix and final rounds, and the result register.
`timescale 1ns / 1ps

module dbh_back import dbh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  input  dbh_cmd_t    cmd,
  output logic        cmd_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] hash_primary,
  output logic [31:0] hash_secondary
);

  dbh_state_t  state;
  dbh_state_t  state_next;
  logic [2:0]  step;
  dbh_cmd_t    cur;
  dbh_words_t  w;
  dbh_words_t  f;
  dbh_words_t  mix_out;
  dbh_words_t  fin_out;
  logic        emit;
  dbh_state_t  after_mix;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
    rotl = (x << r) | (x >> (32 - r));
  endfunction

  // One row of the mix: p -= q; p ^= rotl(q, r); q += s.
  function automatic dbh_words_t mix_row(input logic [2:0] row, input dbh_words_t v);
    dbh_words_t o;
    o = v;
    case (row)
      3'd0: begin o.a = (v.a - v.c) ^ rotl(v.c, 4);  o.c = v.c + v.b; end
      3'd1: begin o.b = (v.b - v.a) ^ rotl(v.a, 6);  o.a = v.a + v.c; end
      3'd2: begin o.c = (v.c - v.b) ^ rotl(v.b, 8);  o.b = v.b + v.a; end
      3'd3: begin o.a = (v.a - v.c) ^ rotl(v.c, 16); o.c = v.c + v.b; end
      3'd4: begin o.b = (v.b - v.a) ^ rotl(v.a, 19); o.a = v.a + v.c; end
      3'd5: begin o.c = (v.c - v.b) ^ rotl(v.b, 4);  o.b = v.b + v.a; end
      default: o = v;
    endcase
    return o;
  endfunction

  // One row of the final step: p ^= q; p -= rotl(q, r).
  function automatic dbh_words_t fin_row(input logic [2:0] row, input dbh_words_t v);
    dbh_words_t o;
    o = v;
    case (row)
      3'd0:    o.c = (v.c ^ v.b) - rotl(v.b, 14);
      3'd1:    o.a = (v.a ^ v.c) - rotl(v.c, 11);
      3'd2:    o.b = (v.b ^ v.a) - rotl(v.a, 25);
      3'd3:    o.c = (v.c ^ v.b) - rotl(v.b, 16);
      3'd4:    o.a = (v.a ^ v.c) - rotl(v.c, 4);
      3'd5:    o.b = (v.b ^ v.a) - rotl(v.a, 14);
      3'd6:    o.c = (v.c ^ v.b) - rotl(v.b, 24);
      default: o = v;
    endcase
    return o;
  endfunction

  assign mix_out = mix_row(step, w);
  assign fin_out = fin_row(step, f);

  always_comb begin
    if (!cur.do_final) begin
      after_mix = ST_FETCH;
    end else if (cur.final_add) begin
      after_mix = ST_FIN_ADD;
    end else begin
      after_mix = ST_EMIT;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_FETCH: begin
        if (cmd_valid) begin
          if (cmd.do_mix) begin
            state_next = ST_MIX_ADD;
          end else if (cmd.do_final) begin
            state_next = cmd.final_add ? ST_FIN_ADD : ST_EMIT;
          end
        end
      end
      ST_MIX_ADD: state_next = ST_MIX;
      ST_MIX:     if (step == MIX_LAST_ROW) state_next = after_mix;
      ST_FIN_ADD: state_next = ST_FIN;
      ST_FIN:     if (step == FIN_LAST_ROW) state_next = ST_EMIT;
      ST_EMIT:    if (!out_valid || out_ready) state_next = ST_FETCH;
      default:    state_next = ST_FETCH;
    endcase
  end

  always_comb begin
    cmd_pop = 1'b0;
    emit    = 1'b0;
    case (state)
      ST_FETCH: cmd_pop = cmd_valid;
      ST_EMIT:  emit    = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FETCH;
      step      <= '0;
      out_valid <= 1'b0;
      w         <= '0;
    end else begin
      state <= state_next;
      if (cmd_pop) begin
        cur <= cmd;
        if (cmd.do_init) begin
          w.a <= cmd.blk[31:0];
          w.b <= cmd.blk[31:0];
          w.c <= cmd.blk[63:32];
        end
      end
      case (state)
        ST_MIX_ADD: begin
          w.a  <= w.a + cur.blk[31:0];
          w.b  <= w.b + cur.blk[63:32];
          w.c  <= w.c + cur.blk[95:64];
          step <= '0;
        end
        ST_MIX: begin
          w    <= mix_out;
          step <= (step == MIX_LAST_ROW) ? '0 : step + 1'b1;
        end
        ST_FIN_ADD: begin
          f.a  <= w.a + cur.fin_blk[31:0];
          f.b  <= w.b + cur.fin_blk[63:32];
          f.c  <= w.c + cur.fin_blk[95:64];
          step <= '0;
        end
        ST_FIN: begin
          f    <= fin_out;
          step <= (step == FIN_LAST_ROW) ? '0 : step + 1'b1;
        end
        default: ;
      endcase
      if (emit) begin
        out_valid      <= 1'b1;
        hash_primary   <= cur.final_add ? f.c : w.c;
        hash_secondary <= cur.final_add ? f.b : w.b;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- src/dual_byte_hash_with_case_fold_top.sv -----
// Top level of the streaming two-word byte hash with optional case folding.
`timescale 1ns / 1ps

// The block takes one message byte per beat and returns the two 32-bit words
// of the lookup3 two-result hash after the beat marked last. The front end
// takes a byte every cycle while its four-entry command queue has room; the
// hash engine takes each full 12-byte block through fetch, block add and six
// mix rounds, and each message end through fetch, block add, seven final
// rounds and result load (fetch and result load for an empty message). Long
// messages run at one byte per cycle while the queue has room; for very short
// messages the hash engine sets the pace. Configuration must be written
// through the cfg port only while no message is in flight; the block does
// not enforce this. Index 0 is the first seed, 1 the second, 2 the case fold bit.

module dual_byte_hash_with_case_fold_top import dbh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // data_byte [7:0], message_length [39:8]
  input  logic [1:0]  s_axis_tuser,  // byte_present [0], first_item [1]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata   // hash_primary [31:0], hash_secondary [63:32]
);

  dbh_cmd_t    front_cmd;
  dbh_cmd_t    head_cmd;
  logic        front_push;
  logic        queue_full;
  logic        queue_not_empty;
  logic        back_pop;
  logic [31:0] hash_primary;
  logic [31:0] hash_secondary;

  assign cfg_ready    = 1'b1;
  assign m_axis_tdata = {hash_secondary, hash_primary};

  dbh_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .data_byte      (s_axis_tdata[7:0]),
    .byte_present   (s_axis_tuser[0]),
    .first_item     (s_axis_tuser[1]),
    .last_item      (s_axis_tlast),
    .message_length (s_axis_tdata[39:8]),
    .cmd_valid      (front_push),
    .cmd            (front_cmd),
    .cmd_full       (queue_full)
  );

  dbh_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_push),
    .push_cmd  (front_cmd),
    .full      (queue_full),
    .pop       (back_pop),
    .not_empty (queue_not_empty),
    .head      (head_cmd)
  );

  dbh_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (queue_not_empty),
    .cmd            (head_cmd),
    .cmd_pop        (back_pop),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .hash_primary   (hash_primary),
    .hash_secondary (hash_secondary)
  );

endmodule
